// File: rtl/mcdt_pkg.sv
// Shared types and constants of the multi-channel deadline timer.
// Used by the channel update unit and the top level; depends on nothing.
package mcdt_pkg;

  localparam int DEF_CHANNELS  = 8;
  localparam int DEF_TIME_BITS = 32;
  localparam int IN_TIME_BITS  = 32;
  localparam int CH_FIELD_BITS = 3;
  localparam int MAX_RESULTS   = 8;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic EV_EXPIRED = 1'b0;
  localparam logic EV_DELETED = 1'b1;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_CONFIG     = 3'd1,
    ACT_START      = 3'd2,
    ACT_STOP       = 3'd3,
    ACT_SET_PERIOD = 3'd4,
    ACT_DELETE     = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic running;
    logic periodic;
  } chan_flags_t;

  typedef struct packed {
    logic valid;
    logic kind;
  } evt_t;

endpackage

// File: rtl/mcdt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the per-channel timer records; no dependencies.
module mcdt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mcdt_chan_alu.sv
// Shared channel update unit: applies one action to one channel record.
// Depends on mcdt_pkg for the action code, flag and event types.
module mcdt_chan_alu #(
  parameter int TIME_BITS = mcdt_pkg::DEF_TIME_BITS
) (
  input  mcdt_pkg::act_t        act,
  input  logic [TIME_BITS-1:0]  tv,
  input  logic                  mode_in,
  input  logic [TIME_BITS-1:0]  period_i,
  input  logic [TIME_BITS-1:0]  ttd_i,
  input  logic [TIME_BITS-1:0]  saved_i,
  input  mcdt_pkg::chan_flags_t flags_i,
  output logic [TIME_BITS-1:0]  period_o,
  output logic [TIME_BITS-1:0]  ttd_o,
  output logic [TIME_BITS-1:0]  saved_o,
  output mcdt_pkg::chan_flags_t flags_o,
  output mcdt_pkg::evt_t        ev
);
  import mcdt_pkg::*;

  logic due;

  // A countdown of zero or one ticks expires on this tick.
  assign due = (ttd_i[TIME_BITS-1:1] == '0);

  always_comb begin
    period_o = period_i;
    ttd_o    = ttd_i;
    saved_o  = saved_i;
    flags_o  = flags_i;
    ev       = '{valid: 1'b0, kind: EV_EXPIRED};
    unique case (act)
      ACT_TICK: begin
        if (flags_i.running) begin
          if (due) begin
            ev = '{valid: 1'b1, kind: EV_EXPIRED};
            if (flags_i.periodic) begin
              ttd_o   = period_i;
              saved_o = '0;
            end else begin
              flags_o.running = 1'b0;
              ttd_o           = '0;
            end
          end else begin
            ttd_o = ttd_i - TIME_BITS'(1);
          end
        end
      end
      ACT_CONFIG: begin
        flags_o.periodic = mode_in;
        period_o         = tv;
      end
      ACT_START: begin
        if (saved_i != '0) begin
          ttd_o = saved_i;
        end else if (tv != '0) begin
          ttd_o = tv;
        end else begin
          ttd_o = period_i;
        end
        saved_o         = '0;
        flags_o.running = 1'b1;
      end
      ACT_STOP: begin
        if (flags_i.running) begin
          saved_o = ttd_i;
        end
        flags_o.running = 1'b0;
      end
      ACT_SET_PERIOD: begin
        period_o = tv;
        if (flags_i.running) begin
          ttd_o = tv;
        end
      end
      ACT_DELETE: begin
        flags_o.running = 1'b0;
        ev = '{valid: 1'b1, kind: EV_DELETED};
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/multi_channel_deadline_timer.sv
// Multi-channel deadline timer: a bank of one-shot or periodic countdown timers.
// A tick is accepted, then visits every channel in turn in the scan, then closes out
// the last event; a command visits only its own channel; an ignored command is
// dropped on acceptance. Each channel visit is one pass through the shared update unit,
// which reads and rewrites that channel's record in the record RAM.
// Reset clears the control state and the per-channel flags; RAM records read as zero
// until written, tracked by one flag per channel, so there is no clearing pass.
module multi_channel_deadline_timer #(
  parameter int CHANNELS  = mcdt_pkg::DEF_CHANNELS,
  parameter int TIME_BITS = mcdt_pkg::DEF_TIME_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream: one command or tick per transaction.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [2:0] channel, [34:3] time_value, [35] mode
  input  logic [2:0]  s_tuser,   // [2:0] action
  // Output stream: one timer event per transaction.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [2:0] event_channel
  output logic [0:0]  m_tuser,   // [0] event_kind
  output logic        m_tlast    // last
);
  import mcdt_pkg::*;

  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RW  = 3 * TIME_BITS;

  // Input field decode.
  logic [CH_FIELD_BITS-1:0] in_ch;
  logic [IN_TIME_BITS-1:0]  in_tv;
  logic                     in_mode;
  act_t                     in_act;
  logic [TIME_BITS-1:0]     tv_clamp;
  logic                     s_fire;
  logic                     in_cmd_ok;

  assign in_ch   = s_tdata[2:0];
  assign in_tv   = s_tdata[34:3];
  assign in_mode = s_tdata[35];
  assign in_act  = act_t'(s_tuser);
  assign s_fire  = s_tvalid && s_tready;

  // Times wider than the counter saturate to its largest value.
  if (TIME_BITS >= IN_TIME_BITS) begin : g_tv_wide
    assign tv_clamp = TIME_BITS'(in_tv);
  end else begin : g_tv_narrow
    assign tv_clamp = (|in_tv[IN_TIME_BITS-1:TIME_BITS]) ? '1 : in_tv[TIME_BITS-1:0];
  end

  // A command is carried out only for a known action and an existing channel.
  assign in_cmd_ok = (in_act <= ACT_DELETE) && (32'(in_ch) < CHANNELS);

  // Sequencer state and latched item.
  state_t               state, state_next;
  logic [CW-1:0]        idx, idx_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  act_t                 act_q;
  logic [TIME_BITS-1:0] tv_q;
  logic                 mode_q;

  // One event is held back so that the final one can be marked last.
  logic                     pend_v, pend_v_next;
  logic [CH_FIELD_BITS-1:0] pend_ch, pend_ch_next;
  logic                     pend_kind, pend_kind_next;

  // Per-channel flags and record-valid bits.
  logic [CHANNELS-1:0] running;
  logic [CHANNELS-1:0] periodic;
  logic [CHANNELS-1:0] rec_valid;

  // Output register.
  logic [CH_FIELD_BITS-1:0] out_ch;
  logic                     out_kind;
  logic                     out_free;
  logic                     push;
  logic [CH_FIELD_BITS-1:0] push_ch;
  logic                     push_kind;
  logic                     push_last;

  // Record RAM and update unit.
  logic                 ram_we;
  logic [CW-1:0]        rd_addr;
  logic [RW-1:0]        ram_rdata;
  logic [RW-1:0]        rec;
  logic [RW-1:0]        rec_new;
  logic [TIME_BITS-1:0] period_o, ttd_o, saved_o;
  chan_flags_t          flags_i, flags_o;
  evt_t                 ev;
  logic                 ev_use;
  logic                 stall;
  logic                 scan_last;

  assign out_free = !m_tvalid || m_tready;

  mcdt_ram #(
    .WIDTH (RW),
    .DEPTH (CHANNELS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (rec_new),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Record layout: {saved, ticks_to_deadline, period}.
  assign rec     = rec_valid[idx] ? ram_rdata : '0;
  assign flags_i = '{running: running[idx], periodic: periodic[idx]};
  assign rec_new = {saved_o, ttd_o, period_o};

  mcdt_chan_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .act      (act_q),
    .tv       (tv_q),
    .mode_in  (mode_q),
    .period_i (rec[TIME_BITS-1:0]),
    .ttd_i    (rec[2*TIME_BITS-1:TIME_BITS]),
    .saved_i  (rec[RW-1:2*TIME_BITS]),
    .flags_i  (flags_i),
    .period_o (period_o),
    .ttd_o    (ttd_o),
    .saved_o  (saved_o),
    .flags_o  (flags_o),
    .ev       (ev)
  );

  // Events beyond the result limit still update state but are not reported.
  assign ev_use    = ev.valid && (cnt < CNT_W'(MAX_RESULTS));
  // A new event can only replace the held one once the output register has room.
  assign stall     = ev_use && pend_v && !out_free;
  assign scan_last = (act_q != ACT_TICK) || (idx == CW'(CHANNELS - 1));

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    cnt_next       = cnt;
    pend_v_next    = pend_v;
    pend_ch_next   = pend_ch;
    pend_kind_next = pend_kind;
    s_tready       = 1'b0;
    ram_we         = 1'b0;
    rd_addr        = idx;
    push           = 1'b0;
    push_ch        = pend_ch;
    push_kind      = pend_kind;
    push_last      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        rd_addr  = (in_act == ACT_TICK) ? '0 : CW'(in_ch);
        if (s_fire) begin
          idx_next    = rd_addr;
          cnt_next    = '0;
          pend_v_next = 1'b0;
          if (in_act == ACT_TICK || in_cmd_ok) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          ram_we = 1'b1;
          if (ev_use) begin
            push           = pend_v;
            pend_v_next    = 1'b1;
            pend_ch_next   = CH_FIELD_BITS'(idx);
            pend_kind_next = ev.kind;
            cnt_next       = cnt + CNT_W'(1);
          end
          if (scan_last) begin
            state_next = ST_DONE;
          end else begin
            idx_next = idx + CW'(1);
            rd_addr  = idx + CW'(1);
          end
        end
      end
      ST_DONE: begin
        if (!pend_v) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          push        = 1'b1;
          push_last   = 1'b1;
          pend_v_next = 1'b0;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      pend_v    <= 1'b0;
      running   <= '0;
      periodic  <= '0;
      rec_valid <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      pend_v <= pend_v_next;
      if (ram_we) begin
        running[idx]   <= flags_o.running;
        periodic[idx]  <= flags_o.periodic;
        rec_valid[idx] <= 1'b1;
      end
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    idx       <= idx_next;
    pend_ch   <= pend_ch_next;
    pend_kind <= pend_kind_next;
    if (s_fire) begin
      act_q  <= in_act;
      tv_q   <= tv_clamp;
      mode_q <= in_mode;
    end
    if (push) begin
      out_ch   <= push_ch;
      out_kind <= push_kind;
      m_tlast  <= push_last;
    end
  end

  assign m_tdata = {{(8 - CH_FIELD_BITS){1'b0}}, out_ch};
  assign m_tuser = out_kind;

  // The sequencer never overwrites an event that is still waiting to be taken.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!m_tvalid || m_tready))
    else $error("event pushed into a full output register");

  // The number of reported events stays within the result limit.
  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_RESULTS))
    else $error("event count beyond result limit");

  // The scan never addresses a channel that does not exist.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (32'(idx) < CHANNELS))
    else $error("scan index out of range");

  // Closing out with nothing held returns to idle at once.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !pend_v) |=> (state == ST_IDLE))
    else $error("finish state did not return to idle");

  // Input is taken only while idle, so no item is accepted during a scan.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_fire)
    else $error("input accepted while busy");

endmodule
